// File: rtl/bfa_pkg.sv
// bfa_pkg: shared types and codes for the bitmap frame allocator.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package bfa_pkg;

	// Fixed field widths
	localparam int FRAME_W  = 12;
	localparam int FCOUNT_W = 13;

	// Reset value of the frame count register
	localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 13'd4096;

	// Request codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_ALLOC = 2'd0;
	localparam logic [1:0] STAT_NOP   = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_FREED = 2'd3;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EVAL,
		S_FREE_DIV,
		S_FREE_RD,
		S_FREE_WR
	} state_t;

endpackage

// File: rtl/bfa_bitmap_ram.sv
// bfa_bitmap_ram: one-read one-write bitmap word memory, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bfa_bitmap_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/bfa_first_free.sv
// bfa_first_free: lowest free bit of one bitmap word below a frame limit.
// No dependencies; used by the top level during the allocation scan.
`timescale 1ns / 1ps

module bfa_first_free #(
	parameter int WIDTH = 32,
	parameter int BI    = 5,
	parameter int GW    = 20
) (
	input  logic [WIDTH-1:0] word,
	input  logic [GW-1:0]    gap,
	output logic             found,
	output logic [BI-1:0]    idx
);

	logic [WIDTH-1:0] free_bits;
	logic [WIDTH-1:0] low_bit;

	// free and below the limit (gap = limit - word base)
	always_comb begin
		for (int b = 0; b < WIDTH; b++) begin
			free_bits[b] = !word[b] && (GW'(b) < gap);
		end
	end

	// isolate the lowest set bit
	assign low_bit = free_bits & (~free_bits + WIDTH'(1));
	assign found   = |free_bits;

	// encode its position, each index bit independently
	always_comb begin
		idx = '0;
		for (int k = 0; k < BI; k++) begin
			for (int b = 0; b < WIDTH; b++) begin
				if (((b >> k) & 1) != 0) begin
					idx[k] = idx[k] | low_bit[b];
				end
			end
		end
	end

endmodule

// File: rtl/bitmap_frame_allocator_unit.sv
// No-op and zero-limit requests give their result in the cycle after start; a free passes
// through divide, read and write states; a scan reads and evaluates one word per step, from
// the lowest word that may hold a free frame, until a grant or the limit (no free frame).
// Throughput: one item at a time, busy high while in work; done pulses once, no stall.
// Reset: frame_count = 4096; busy stays high through a clearing pass that zeroes the
// bitmap one word per cycle, over all ceil(MAX_FRAMES/WORD_BITS) words (128 by default).
`timescale 1ns / 1ps

module bitmap_frame_allocator_unit
	import bfa_pkg::*;
#(
	parameter int MAX_FRAMES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                opcode,
	input  logic [FRAME_W-1:0]  page_frame,
	input  logic                kernel_page,
	input  logic                rw_page,
	input  logic                cfg_we,
	input  logic [FCOUNT_W-1:0] cfg_wdata,
	output logic                done,
	output logic [1:0]          status,
	output logic [FRAME_W-1:0]  new_frame,
	output logic                present,
	output logic                writable,
	output logic                user_mode
);

	localparam int BM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
	localparam int BI = $clog2(WORD_BITS);
	localparam int LW = $clog2(MAX_FRAMES + 1);
	localparam int CW = (LW > FCOUNT_W) ? LW : FCOUNT_W;
	localparam int BW = CW + 7;
	// reciprocal for frame / WORD_BITS, exact for 12-bit frames
	localparam int RS = 19;
	localparam int RW = RS + 1;
	localparam int RECIP = ((1 << RS) + WORD_BITS - 1) / WORD_BITS;
	localparam int PW = (RS + AW > FRAME_W + RW) ? RS + AW : FRAME_W + RW;

	state_t state_q, state_d;

	logic [FCOUNT_W-1:0]  frame_count_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        hint_q;
	logic [BW-1:0]        hint_base_q;
	logic [AW-1:0]        w_q;
	logic [BW-1:0]        base_q;
	logic [BW-1:0]        lim_q;
	logic [FRAME_W-1:0]   pf_q;
	logic                 kern_q;
	logic                 wr_q;
	logic [AW-1:0]        q_s1;
	logic [BI-1:0]        bit_s2;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	logic                 accept;
	logic [BW-1:0]        lim_now;
	logic [BW-1:0]        gap;
	logic                 ff_found;
	logic [BI-1:0]        ff_idx;
	logic [BW-1:0]        found_frame;
	logic [PW-1:0]        prod;
	logic [BW-1:0]        q_base;
	logic [BW-1:0]        pf_rem;
	logic [WORD_BITS-1:0] one_word;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// search limit: frame count saturated to MAX_FRAMES
	always_comb begin
		if (CW'(frame_count_q) > CW'(MAX_FRAMES)) begin
			lim_now = BW'(MAX_FRAMES);
		end else begin
			lim_now = BW'(frame_count_q);
		end
	end

	assign gap         = lim_q - base_q;
	assign found_frame = base_q + BW'(ff_idx);
	assign prod        = PW'(pf_q) * PW'(RECIP);
	assign q_base      = BW'(q_s1) * BW'(WORD_BITS);
	assign pf_rem      = BW'(pf_q) - q_base;
	assign one_word    = WORD_BITS'(1);

	bfa_bitmap_ram #(
		.DEPTH(BM_WORDS),
		.WIDTH(WORD_BITS),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	bfa_first_free #(
		.WIDTH(WORD_BITS),
		.BI   (BI),
		.GW   (BW)
	) u_first_free (
		.word (rd_data),
		.gap  (gap),
		.found(ff_found),
		.idx  (ff_idx)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = w_q;
		wr_en   = 1'b0;
		wr_addr = w_q;
		wr_data = rd_data | (one_word << ff_idx);
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == AW'(BM_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_ALLOC) begin
						if (page_frame == '0 && lim_now != '0) begin
							state_d = S_SCAN_RD;
						end
					end else if (page_frame != '0 &&
					             BW'(page_frame) < BW'(MAX_FRAMES)) begin
						state_d = S_FREE_DIV;
					end
				end
			end
			S_SCAN_RD: begin
				if (base_q >= lim_q) begin
					state_d = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_SCAN_EVAL;
				end
			end
			S_SCAN_EVAL: begin
				if (ff_found) begin
					wr_en   = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_FREE_DIV: begin
				state_d = S_FREE_RD;
			end
			S_FREE_RD: begin
				rd_en   = 1'b1;
				rd_addr = q_s1;
				state_d = S_FREE_WR;
			end
			S_FREE_WR: begin
				wr_en   = 1'b1;
				wr_addr = q_s1;
				wr_data = rd_data & ~(one_word << bit_s2);
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers: config, clear counter, free-word hint, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FCOUNT_RESET;
			clr_q         <= '0;
			hint_q        <= '0;
			hint_base_q   <= '0;
			done          <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				frame_count_q <= cfg_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				S_IDLE: begin
					if (accept && !(opcode == OP_ALLOC && page_frame == '0 &&
					                lim_now != '0) &&
					    !(opcode == OP_FREE && page_frame != '0 &&
					      BW'(page_frame) < BW'(MAX_FRAMES))) begin
						done <= 1'b1;
					end
				end
				S_SCAN_RD: begin
					if (base_q >= lim_q) begin
						done <= 1'b1;
					end
				end
				S_SCAN_EVAL: begin
					// words below the one just hit are all used
					if (ff_found) begin
						hint_q      <= w_q;
						hint_base_q <= base_q;
						done        <= 1'b1;
					end
				end
				S_FREE_RD: begin
					if (q_s1 < hint_q) begin
						hint_q      <= q_s1;
						hint_base_q <= q_base;
					end
				end
				S_FREE_WR: begin
					done <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					pf_q      <= page_frame;
					kern_q    <= kernel_page;
					wr_q      <= rw_page;
					w_q       <= hint_q;
					base_q    <= hint_base_q;
					lim_q     <= lim_now;
					present   <= 1'b0;
					writable  <= 1'b0;
					user_mode <= 1'b0;
					new_frame <= '0;
					if (opcode == OP_ALLOC) begin
						if (page_frame != '0) begin
							status    <= STAT_NOP;
							new_frame <= page_frame;
						end else begin
							status <= STAT_FULL;
						end
					end else if (page_frame == '0) begin
						status <= STAT_NOP;
					end else begin
						status <= STAT_FREED;
					end
				end
			end
			S_SCAN_RD: begin
				if (base_q >= lim_q) begin
					status    <= STAT_FULL;
					new_frame <= '0;
				end
			end
			S_SCAN_EVAL: begin
				if (ff_found) begin
					status    <= STAT_ALLOC;
					new_frame <= found_frame[FRAME_W-1:0];
					present   <= 1'b1;
					writable  <= wr_q;
					user_mode <= !kern_q;
				end else begin
					w_q    <= w_q + AW'(1);
					base_q <= base_q + BW'(WORD_BITS);
				end
			end
			S_FREE_DIV: begin
				q_s1 <= prod[RS +: AW];
			end
			S_FREE_RD: begin
				bit_s2 <= pf_rem[BI-1:0];
			end
			S_FREE_WR: begin
				status    <= STAT_FREED;
				new_frame <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule
